>>> hw/rtl/ttop_pkg.sv
// Package for the timer table: shared types, op and status codes, result struct.
// Used by every module in hw/rtl; depends on nothing.
package ttop_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int MAX_FIRES_DEF = 63;
	localparam int QUEUE_DEPTH   = 2;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_CAPPED  = 2'd3
	} status_t;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_FIRE = 1'b1;

	// classified request handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] interval;
		logic        repeat_req;
		logic [7:0]  owner_tag;
		logic [31:0] target_id;
		logic [31:0] delta;
	} req_t;

	typedef struct packed {
		logic        kind;
		status_t     status;
		logic [31:0] new_id;
		logic [31:0] fired_id;
		logic [7:0]  fired_owner;
		logic [63:0] now_time;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN,
		B_CHECK,
		B_EMIT,
		B_DONE
	} bstate_t;

endpackage

>>> hw/rtl/timer_table_oneshot_periodic.sv
// Top level of the timer table: front request queue plus back sequencer.
// Depends on ttop_pkg, ttop_front and ttop_back.
//
// Input channel s_axis: one request per handshake (create, cancel, advance),
// with the op on tuser.
// Output channel m_axis: result items; each request ends with one completion
// (tuser=0, tlast=1). An advance puts its fire events (tuser=1) first.
// The front holds a two-entry queue, so requests are taken while the back
// works. A create passes from the idle state to the done state and then into
// the output register. Cancel and advance visit one rank at a time in a scan
// and a check state (the rank-to-slot lookup is registered), and each fire
// passes through an emit state that waits on the one-entry output register.
// Reset clears all slots, sets the id counter to one and the time to zero.
// When the receiver stalls, the back holds in place until the output
// register frees; the queue keeps accepting until full.
module timer_table_oneshot_periodic #(
	parameter int SLOTS     = ttop_pkg::SLOTS_DEF,
	parameter int MAX_FIRES = ttop_pkg::MAX_FIRES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// interval[31:0], repeat_req[32], owner_tag[40:33],
	// target_id[72:41], delta[104:73], zero fill
	input  logic [111:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,   // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], new_id[33:2], fired_id[65:34], fired_owner[73:66],
	// now_time[137:74], zero fill
	output logic [143:0] m_axis_tdata,
	output logic         m_axis_tuser,   // kind
	output logic         m_axis_tlast
);
	import ttop_pkg::*;

	req_t in_req, q_req;
	res_t res;
	logic q_valid, q_ready;

	assign in_req.op         = op_t'(s_axis_tuser);
	assign in_req.interval   = s_axis_tdata[31:0];
	assign in_req.repeat_req = s_axis_tdata[32];
	assign in_req.owner_tag  = s_axis_tdata[40:33];
	assign in_req.target_id  = s_axis_tdata[72:41];
	assign in_req.delta      = s_axis_tdata[104:73];

	ttop_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
		.q_valid, .q_ready, .q_req
	);

	ttop_back #(.SLOTS(SLOTS), .MAX_FIRES(MAX_FIRES)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {6'd0, res.now_time, res.fired_owner, res.fired_id,
		res.new_id, res.status};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;
endmodule

>>> hw/rtl/ttop_front.sv
// Front part: accepts input requests, decodes the op and queues them.
// Depends on ttop_pkg.
module ttop_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ttop_pkg::req_t       in_req,
	output logic                 q_valid,
	input  logic                 q_ready,
	output ttop_pkg::req_t       q_req
);
	import ttop_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	req_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;
	req_t          cls;

	// unknown op codes keep op, repeat flag and owner tag; interval, target id and delta are cleared
	always_comb begin
		cls = in_req;
		if (in_req.op == OP_NONE) begin
			cls.interval = '0;
			cls.target_id = '0;
			cls.delta = '0;
		end
	end

	assign in_ready = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_req    = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

>>> hw/rtl/ttop_back.sv
// Back part: timer slot table and sequencer for create, cancel and advance.
// Depends on ttop_pkg; results leave through a one-entry output register.
module ttop_back #(
	parameter int SLOTS     = ttop_pkg::SLOTS_DEF,
	parameter int MAX_FIRES = ttop_pkg::MAX_FIRES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  ttop_pkg::req_t q_req,
	output logic           out_valid,
	input  logic           out_ready,
	output ttop_pkg::res_t out_res
);
	import ttop_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = $clog2(SLOTS + 1);
	localparam int FW = 6;

	logic              valid_q [SLOTS];
	logic [RW-1:0]     rank_q  [SLOTS];
	logic [31:0]       id_q    [SLOTS];
	logic [7:0]        own_q   [SLOTS];
	logic              per_q   [SLOTS];
	logic [31:0]       ivl_q   [SLOTS];
	logic [63:0]       exp_q   [SLOTS];

	logic [31:0]   idc_q;
	logic [63:0]   now_q;
	logic [RW-1:0] act_q;
	bstate_t       st_q, st_d;
	req_t          req_q;
	logic [RW-1:0] pos_q;     // rank being visited
	logic [SW-1:0] sel_q;     // slot holding that rank
	logic          hit_q;
	logic          fired_q;
	logic [FW-1:0] nfire_q;
	logic          capped_q;
	logic          found_q;
	res_t          res_q;
	logic          ov_q;

	logic [SW-1:0] free_idx, rank_idx;
	logic          free_ok, rank_ok;
	logic          out_free;
	logic          load_out;
	status_t       done_status;
	logic [31:0]   done_id;

	assign out_free  = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_res   = res_q;
	assign q_ready   = (st_q == B_IDLE);
	assign load_out  = (st_q == B_EMIT || st_q == B_DONE) && out_free;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		free_ok  = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SW'(i);
				free_ok  = 1'b1;
			end
		end
	end

	// slot whose rank equals pos_q (ranks of valid slots are unique)
	always_comb begin
		rank_idx = '0;
		rank_ok  = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_q[i] && rank_q[i] == pos_q) begin
				rank_idx = SW'(i);
				rank_ok  = 1'b1;
			end
		end
	end

	// completion status and id for the request in hand
	always_comb begin
		done_status = ST_OK;
		done_id     = '0;
		if (req_q.op == OP_CREATE) begin
			if (found_q) done_id = idc_q - 32'd1;
			else done_status = ST_FULL;
		end else if (req_q.op == OP_CANCEL && !found_q)
			done_status = ST_MISSING;
		else if (req_q.op == OP_ADVANCE && capped_q)
			done_status = ST_CAPPED;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE:  if (q_valid) begin
				st_d = (q_req.op == OP_CANCEL || q_req.op == OP_ADVANCE) ? B_SCAN : B_DONE;
			end
			B_SCAN: begin
				if (pos_q < act_q) st_d = B_CHECK;
				else if (req_q.op == OP_ADVANCE && fired_q && !capped_q) st_d = B_SCAN;
				else st_d = B_DONE;
			end
			B_CHECK: begin
				if (!hit_q) st_d = B_SCAN;
				else if (req_q.op == OP_CANCEL || nfire_q == FW'(MAX_FIRES)) st_d = B_DONE;
				else st_d = B_EMIT;
			end
			B_EMIT:  if (out_free) st_d = B_SCAN;
			B_DONE:  if (out_free) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			ov_q     <= 1'b0;
			idc_q    <= 32'd1;
			now_q    <= '0;
			act_q    <= '0;
			req_q    <= '0;
			pos_q    <= '0;
			sel_q    <= '0;
			hit_q    <= 1'b0;
			fired_q  <= 1'b0;
			nfire_q  <= '0;
			capped_q <= 1'b0;
			found_q  <= 1'b0;
			res_q    <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else begin
			st_q <= st_d;
			if (load_out) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (st_q)
				B_IDLE: if (q_valid) begin
					req_q    <= q_req;
					pos_q    <= '0;
					fired_q  <= 1'b0;
					nfire_q  <= '0;
					capped_q <= 1'b0;
					found_q  <= 1'b0;
					if (q_req.op == OP_ADVANCE) now_q <= now_q + 64'(q_req.delta);
					if (q_req.op == OP_CREATE && free_ok) begin
						for (int i = 0; i < SLOTS; i++)
							if (valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
						valid_q[free_idx] <= 1'b1;
						rank_q[free_idx]  <= '0;
						id_q[free_idx]    <= idc_q;
						own_q[free_idx]   <= q_req.owner_tag;
						per_q[free_idx]   <= q_req.repeat_req;
						ivl_q[free_idx]   <= q_req.interval;
						exp_q[free_idx]   <= now_q + 64'(q_req.interval);
						act_q <= act_q + 1'b1;
						idc_q <= idc_q + 32'd1;
						found_q <= 1'b1;
					end
				end
				B_SCAN: begin
					if (pos_q >= act_q && req_q.op == OP_ADVANCE && fired_q
							&& !capped_q) begin
						// start another pass
						pos_q   <= '0;
						fired_q <= 1'b0;
					end else if (pos_q < act_q) begin
						sel_q <= rank_idx;
						if (req_q.op == OP_CANCEL)
							hit_q <= rank_ok && id_q[rank_idx] == req_q.target_id;
						else
							hit_q <= rank_ok && exp_q[rank_idx] <= now_q;
					end
				end
				B_CHECK: begin
					if (!hit_q) pos_q <= pos_q + 1'b1;
					else if (req_q.op == OP_CANCEL) begin
						found_q <= 1'b1;
						// free and end scan
						valid_q[sel_q] <= 1'b0;
						for (int i = 0; i < SLOTS; i++)
							if (valid_q[i] && rank_q[i] > rank_q[sel_q])
								rank_q[i] <= rank_q[i] - 1'b1;
						act_q <= act_q - 1'b1;
						pos_q <= act_q;
					end else if (nfire_q == FW'(MAX_FIRES)) begin
						capped_q <= 1'b1;
						pos_q    <= act_q;
					end
				end
				B_EMIT: if (out_free) begin
					res_q <= '{kind: KIND_FIRE, status: ST_OK, new_id: '0,
						fired_id: id_q[sel_q], fired_owner: own_q[sel_q],
						now_time: now_q, last: 1'b0};
					fired_q <= 1'b1;
					nfire_q <= nfire_q + 1'b1;
					if (per_q[sel_q]) begin
						exp_q[sel_q] <= exp_q[sel_q] + 64'(ivl_q[sel_q]);
						pos_q <= pos_q + 1'b1;
					end else begin
						// freed slot: later ranks shift down, keep position
						valid_q[sel_q] <= 1'b0;
						for (int i = 0; i < SLOTS; i++)
							if (valid_q[i] && rank_q[i] > rank_q[sel_q])
								rank_q[i] <= rank_q[i] - 1'b1;
						act_q <= act_q - 1'b1;
					end
				end
				B_DONE: if (out_free) begin
					res_q <= '{kind: KIND_DONE, status: done_status, new_id: done_id,
						fired_id: '0, fired_owner: '0, now_time: now_q, last: 1'b1};
				end
				default: ;
			endcase
		end
	end
endmodule

>>> hw/rtl/ttop_checker.sv
// Port-level checker for the timer table, bound to the top level.
// Depends on ttop_pkg for the status codes.
module ttop_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata,
	input logic         m_axis_tuser,
	input logic         m_axis_tlast
);
	import ttop_pkg::*;

	// fire events are never the final result
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast) else $error("fire with last");

	// completions are always last
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast) else $error("completion not last");

	// fire events carry ok status
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == ST_OK)
		else $error("fire status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output dropped");
endmodule

bind timer_table_oneshot_periodic ttop_checker u_checker (.*);
